@@ rtl/core/lru_page_replacer_with_fifo_tlb_assert.svh @@
// Assertion macros used by the checker file of this block.
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is asserted.
`ifndef LRU_PAGE_REPLACER_WITH_FIFO_TLB_ASSERT_SVH
`define LRU_PAGE_REPLACER_WITH_FIFO_TLB_ASSERT_SVH

// Same-cycle implication.
`define LRUTLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrutlb check failed");

// Next-cycle implication.
`define LRUTLB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrutlb check failed");

`endif

@@ rtl/core/lrutlb_pkg.sv @@
package lrutlb_pkg;

    localparam int PAGE_W     = 16;
    localparam int IN_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FCOUNT_W   = 4;
    localparam int TCOUNT_W   = 3;
    localparam int TIME_CFG_W = 16;
    localparam int COST_W     = 19;
    localparam int ACCESS_W   = 18;
    localparam int TOTAL_W    = 40;
    localparam int CNT_W      = 32;
    localparam int FRAME_O_W  = 3;

    localparam logic [FCOUNT_W-1:0]   FRAME_COUNT_RST = 4'd3;
    localparam logic [TCOUNT_W-1:0]   TLB_COUNT_RST   = 3'd4;
    localparam logic                  USE_TLB_RST     = 1'b1;
    localparam logic [TIME_CFG_W-1:0] TLB_TIME_RST    = 16'd1;
    localparam logic [TIME_CFG_W-1:0] MEM_TIME_RST    = 16'd10;
    localparam logic [TIME_CFG_W-1:0] FAULT_TIME_RST  = 16'd100;

    typedef enum logic [1:0] {
        OUTCOME_TLB_HIT   = 2'd0,
        OUTCOME_TABLE_HIT = 2'd1,
        OUTCOME_FAULT     = 2'd2
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT = 3'd0,
        REG_TLB_COUNT   = 3'd1,
        REG_USE_TLB     = 3'd2,
        REG_TLB_TIME    = 3'd3,
        REG_MEM_TIME    = 3'd4,
        REG_FAULT_TIME  = 3'd5
    } cfg_reg_t;

    // First member sits in the highest bits, so outcome lands at bit 0.
    typedef struct packed {
        logic [CNT_W-1:0]     reference_total;
        logic [TOTAL_W-1:0]   time_total;
        logic [CNT_W-1:0]     fault_total;
        logic [ACCESS_W-1:0]  access_time;
        logic [FRAME_O_W-1:0] frame_index;
        logic [PAGE_W-1:0]    evicted_page;
        logic                 evicted_valid;
        outcome_t             outcome;
    } result_t;

    localparam int OUT_W = $bits(result_t);

    // Request from the frame table to the TLB for one reference.
    typedef struct packed {
        logic                fire;
        logic                use_tlb;
        logic                table_hit;
        logic                evict_en;
        logic [PAGE_W-1:0]   lookup_page;
        logic [PAGE_W-1:0]   evict_page;
        logic [TCOUNT_W-1:0] tlb_count;
    } tlb_cmd_t;

endpackage

@@ rtl/core/lrutlb_tlb.sv @@
module lrutlb_tlb #(
    parameter int TLB_ENTRIES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lrutlb_pkg::tlb_cmd_t cmd,
    output logic                tlb_hit
);
    import lrutlb_pkg::*;

    localparam int TIDX_W = $clog2(TLB_ENTRIES > 1 ? TLB_ENTRIES : 2);
    localparam int TC_W   = $clog2(TLB_ENTRIES + 1);

    logic [PAGE_W-1:0]      page_reg  [TLB_ENTRIES];
    logic [PAGE_W-1:0]      page_next [TLB_ENTRIES];
    logic [TIDX_W-1:0]      rank_reg  [TLB_ENTRIES];
    logic [TIDX_W-1:0]      rank_next [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;

    logic [TIDX_W-1:0]      rm_slot;
    logic                   rm_found;
    logic [TIDX_W-1:0]      old_slot;
    logic                   old_found;
    logic [TIDX_W-1:0]      free_slot;
    logic                   free_found;
    logic [TC_W-1:0]        count;
    logic [TC_W-1:0]        limit;
    logic                   do_insert;
    logic [TLB_ENTRIES-1:0] v1;
    logic [TIDX_W-1:0]      r1 [TLB_ENTRIES];

    always_comb
    begin
        if (cmd.tlb_count == '0)
        begin
            limit = TC_W'(1);
        end
        else if (int'(cmd.tlb_count) > TLB_ENTRIES)
        begin
            limit = TC_W'(TLB_ENTRIES);
        end
        else
        begin
            limit = TC_W'(cmd.tlb_count);
        end
    end

    always_comb
    begin
        tlb_hit    = 1'b0;
        rm_found   = 1'b0;
        rm_slot    = '0;
        old_found  = 1'b0;
        old_slot   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        count      = '0;
        v1         = valid_reg;
        r1         = rank_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        page_next  = page_reg;

        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (valid_reg[i] && page_reg[i] == cmd.lookup_page)
            begin
                tlb_hit = 1'b1;
            end
            if (!rm_found && valid_reg[i] && page_reg[i] == cmd.evict_page)
            begin
                rm_found = 1'b1;
                rm_slot  = TIDX_W'(i);
            end
        end

        // drop the frame victim and close the gap in the FIFO order
        if (cmd.evict_en && rm_found)
        begin
            v1[rm_slot] = 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (v1[i] && rank_reg[i] > rank_reg[rm_slot])
                begin
                    r1[i] = rank_reg[i] - 1'b1;
                end
            end
        end

        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            count = count + TC_W'(v1[i]);
        end

        do_insert = cmd.use_tlb && !(cmd.table_hit && tlb_hit);

        valid_next = v1;
        rank_next  = r1;
        if (do_insert)
        begin
            // full: retire the oldest entry first
            if (count >= limit)
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                begin
                    if (!old_found && v1[i] && r1[i] == '0)
                    begin
                        old_found = 1'b1;
                        old_slot  = TIDX_W'(i);
                    end
                end
                if (old_found)
                begin
                    valid_next[old_slot] = 1'b0;
                    for (int i = 0; i < TLB_ENTRIES; i++)
                    begin
                        if (valid_next[i] && r1[i] > r1[old_slot])
                        begin
                            rank_next[i] = r1[i] - 1'b1;
                        end
                    end
                end
                count = count - 1'b1;
            end
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (!free_found && !valid_next[i])
                begin
                    free_found = 1'b1;
                    free_slot  = TIDX_W'(i);
                end
            end
            if (free_found)
            begin
                valid_next[free_slot] = 1'b1;
                page_next[free_slot]  = cmd.lookup_page;
                rank_next[free_slot]  = TIDX_W'(count);
            end
        end

        if (!cmd.fire)
        begin
            valid_next = valid_reg;
            rank_next  = rank_reg;
            page_next  = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
                page_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            page_reg  <= page_next;
        end
    end

endmodule

@@ rtl/core/lru_page_replacer_with_fifo_tlb.sv @@
// Pipeline: a reference transfers into the input register; its result is
// computed once the result register is empty or draining and is offered from
// the result register (one input register, one result register).
// Throughput: one reference per cycle while the result stream is not stalled;
// frame and TLB tags are compared in parallel and all ranks update in the same cycle as the lookup.
// Reset: all tables, ranks and totals clear at once and the configuration
// returns to its defaults; there is no clearing pass.
module lru_page_replacer_with_fifo_tlb #(
    parameter int FRAMES      = 8,
    parameter int TLB_ENTRIES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrutlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrutlb_pkg::CFG_DATA_W-1:0] cfg_data,
    // reference stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lrutlb_pkg::IN_W-1:0]       s_tdata,  // page_number[15:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // outcome[1:0], evicted_valid[2], evicted_page[18:3], frame_index[21:19],
    // access_time[39:22], fault_total[71:40], time_total[111:72],
    // reference_total[143:112]
    output logic [lrutlb_pkg::OUT_W-1:0]      m_tdata
);
    import lrutlb_pkg::*;

    localparam int FIDX_W = $clog2(FRAMES > 1 ? FRAMES : 2);
    localparam int FU_W   = $clog2(FRAMES + 1);

    // configuration
    logic [FCOUNT_W-1:0]   frame_count_reg, frame_count_next;
    logic [TCOUNT_W-1:0]   tlb_count_reg, tlb_count_next;
    logic                  use_tlb_reg, use_tlb_next;
    logic [TIME_CFG_W-1:0] tlb_time_reg, tlb_time_next;
    logic [TIME_CFG_W-1:0] mem_time_reg, mem_time_next;
    logic [TIME_CFG_W-1:0] fault_time_reg, fault_time_next;

    // pipeline
    logic              in_valid_reg, in_valid_next;
    logic [PAGE_W-1:0] in_page_reg, in_page_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;
    logic              fire;

    // frame table and totals
    logic [PAGE_W-1:0] frame_page_reg  [FRAMES];
    logic [PAGE_W-1:0] frame_page_next [FRAMES];
    logic [FIDX_W-1:0] frame_rank_reg  [FRAMES];
    logic [FIDX_W-1:0] frame_rank_next [FRAMES];
    logic [FU_W-1:0]   frames_used_reg, frames_used_next;
    logic [CNT_W-1:0]  fault_total_reg, fault_total_next;
    logic [TOTAL_W-1:0] time_total_reg, time_total_next;
    logic [CNT_W-1:0]  ref_total_reg, ref_total_next;

    // lookup
    logic              found;
    logic [FIDX_W-1:0] found_idx;
    logic              victim_found;
    logic [FIDX_W-1:0] victim_idx;
    logic [FU_W-1:0]   limit;
    logic              replace;
    logic [FIDX_W-1:0] frame;
    logic              tlb_hit;
    tlb_cmd_t          tlb_cmd;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] t_cost, m_cost, f_cost;
    logic [TOTAL_W:0]  time_sum;
    outcome_t          outcome;

    // The user must land configuration only while idle, unenforced here; writes are taken at once.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        tlb_count_next   = tlb_count_reg;
        use_tlb_next     = use_tlb_reg;
        tlb_time_next    = tlb_time_reg;
        mem_time_next    = mem_time_reg;
        fault_time_next  = fault_time_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_COUNT: frame_count_next = cfg_data[FCOUNT_W-1:0];
                REG_TLB_COUNT:   tlb_count_next   = cfg_data[TCOUNT_W-1:0];
                REG_USE_TLB:     use_tlb_next     = cfg_data[0];
                REG_TLB_TIME:    tlb_time_next    = cfg_data;
                REG_MEM_TIME:    mem_time_next    = cfg_data;
                REG_FAULT_TIME:  fault_time_next  = cfg_data;
                default:         ;  // unused index: drop the write
            endcase
        end
    end

    // Advance the work stage whenever the result register is empty or
    // draining this cycle; take a new reference whenever the input register
    // will be free.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_page_next  = in_page_reg;
        if (fire)
        begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_page_next  = s_tdata[PAGE_W-1:0];
        end
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Frame limit, with out-of-range settings folded into 1..FRAMES.
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            limit = FU_W'(1);
        end
        else if (int'(frame_count_reg) > FRAMES)
        begin
            limit = FU_W'(FRAMES);
        end
        else
        begin
            limit = FU_W'(frame_count_reg);
        end
    end

    // Parallel tag compare over the used frames; the victim is the frame
    // whose LRU rank is zero.
    always_comb
    begin
        found        = 1'b0;
        found_idx    = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (FU_W'(i) < frames_used_reg)
            begin
                if (!found && frame_page_reg[i] == in_page_reg)
                begin
                    found     = 1'b1;
                    found_idx = FIDX_W'(i);
                end
                if (!victim_found && frame_rank_reg[i] == '0)
                begin
                    victim_found = 1'b1;
                    victim_idx   = FIDX_W'(i);
                end
            end
        end
        replace = !found && (frames_used_reg >= limit) && (frames_used_reg != '0);
        priority if (found)
        begin
            frame = found_idx;
        end
        else if (replace)
        begin
            frame = victim_idx;
        end
        else
        begin
            frame = FIDX_W'(frames_used_reg);
        end
    end

    assign tlb_cmd.fire        = fire;
    assign tlb_cmd.use_tlb     = use_tlb_reg;
    assign tlb_cmd.table_hit   = found;
    assign tlb_cmd.evict_en    = replace;
    assign tlb_cmd.lookup_page = in_page_reg;
    assign tlb_cmd.evict_page  = frame_page_reg[victim_idx];
    assign tlb_cmd.tlb_count   = tlb_count_reg;

    lrutlb_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tlb_cmd),
        .tlb_hit (tlb_hit)
    );

    // Frame table update: touch on a hit or a replacement moves the frame
    // to MRU and closes the gap above its old rank; a fill appends at MRU.
    always_comb
    begin
        frame_page_next  = frame_page_reg;
        frame_rank_next  = frame_rank_reg;
        frames_used_next = frames_used_reg;
        if (fire)
        begin
            if (found || replace)
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (FU_W'(i) < frames_used_reg && frame_rank_reg[i] > frame_rank_reg[frame])
                    begin
                        frame_rank_next[i] = frame_rank_reg[i] - 1'b1;
                    end
                end
                frame_rank_next[frame] = FIDX_W'(frames_used_reg - 1'b1);
                if (replace)
                begin
                    frame_page_next[frame] = in_page_reg;
                end
            end
            else
            begin
                frame_page_next[frame] = in_page_reg;
                frame_rank_next[frame] = FIDX_W'(frames_used_reg);
                frames_used_next       = frames_used_reg + 1'b1;
            end
        end
    end

    // Access cost and running totals.
    always_comb
    begin
        t_cost = COST_W'(tlb_time_reg);
        m_cost = COST_W'(mem_time_reg);
        f_cost = COST_W'(fault_time_reg);
        priority if (!found)
        begin
            outcome = OUTCOME_FAULT;
            cost    = f_cost + (m_cost << 1) + (use_tlb_reg ? (t_cost << 1) : '0);
        end
        else if (use_tlb_reg && tlb_hit)
        begin
            outcome = OUTCOME_TLB_HIT;
            cost    = t_cost + m_cost;
        end
        else if (use_tlb_reg)
        begin
            outcome = OUTCOME_TABLE_HIT;
            cost    = (t_cost << 1) + (m_cost << 1);
        end
        else
        begin
            outcome = OUTCOME_TABLE_HIT;
            cost    = m_cost << 1;
        end

        time_sum = {1'b0, time_total_reg} + (TOTAL_W + 1)'(cost);

        fault_total_next = fault_total_reg;
        time_total_next  = time_total_reg;
        ref_total_next   = ref_total_reg;
        if (fire)
        begin
            if (!found && fault_total_reg != '1)
            begin
                fault_total_next = fault_total_reg + 1'b1;
            end
            if (ref_total_reg != '1)
            begin
                ref_total_next = ref_total_reg + 1'b1;
            end
            // saturate on carry out of the total
            time_total_next = time_sum[TOTAL_W] ? '1 : time_sum[TOTAL_W-1:0];
        end

        result_next = result_reg;
        if (fire)
        begin
            result_next.outcome         = outcome;
            result_next.evicted_valid   = replace;
            result_next.evicted_page    = replace ? frame_page_reg[victim_idx] : '0;
            result_next.frame_index     = FRAME_O_W'(frame);
            result_next.access_time     = cost[COST_W-1:ACCESS_W] != '0 ? '1
                                                                        : cost[ACCESS_W-1:0];
            result_next.fault_total     = fault_total_next;
            result_next.time_total      = time_total_next;
            result_next.reference_total = ref_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RST;
            tlb_count_reg   <= TLB_COUNT_RST;
            use_tlb_reg     <= USE_TLB_RST;
            tlb_time_reg    <= TLB_TIME_RST;
            mem_time_reg    <= MEM_TIME_RST;
            fault_time_reg  <= FAULT_TIME_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frames_used_reg <= '0;
            fault_total_reg <= '0;
            time_total_reg  <= '0;
            ref_total_reg   <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page_reg[i] <= '0;
                frame_rank_reg[i] <= '0;
            end
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            tlb_count_reg   <= tlb_count_next;
            use_tlb_reg     <= use_tlb_next;
            tlb_time_reg    <= tlb_time_next;
            mem_time_reg    <= mem_time_next;
            fault_time_reg  <= fault_time_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            frames_used_reg <= frames_used_next;
            fault_total_reg <= fault_total_next;
            time_total_reg  <= time_total_next;
            ref_total_reg   <= ref_total_next;
            frame_page_reg  <= frame_page_next;
            frame_rank_reg  <= frame_rank_next;
        end
    end

    // payload registers: hold until the next transfer
    always_ff @(posedge clk)
    begin
        in_page_reg <= in_page_next;
        result_reg  <= result_next;
    end

endmodule

@@ rtl/core/lrutlb_checker.sv @@
`include "lru_page_replacer_with_fifo_tlb_assert.svh"

module lrutlb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [lrutlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [lrutlb_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [lrutlb_pkg::IN_W-1:0]       s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lrutlb_pkg::OUT_W-1:0]      m_tdata
);
    import lrutlb_pkg::*;

    result_t res;
    logic    cfg_seen;
    logic    in_seen;

    assign res      = m_tdata;
    assign cfg_seen = cfg_valid && cfg_ready && (cfg_index != '0 || cfg_data != '0);
    assign in_seen  = s_tvalid && s_tready && (s_tdata != '0 || cfg_seen);

    // stalled result holds
    `LRUTLB_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // only a fault can replace a resident page
    `LRUTLB_ASSERT_IMP(a_evict_fault, clk, rst_n, m_tvalid && res.evicted_valid, res.outcome == OUTCOME_FAULT)
    // without a victim the evicted page reads as zero, unless in_seen holds
    `LRUTLB_ASSERT_IMP(a_evict_zero, clk, rst_n, m_tvalid && !res.evicted_valid, res.evicted_page == '0 || in_seen)
    // faults never outnumber references
    `LRUTLB_ASSERT_IMP(a_totals, clk, rst_n, m_tvalid, res.reference_total >= res.fault_total)

endmodule

bind lru_page_replacer_with_fifo_tlb lrutlb_checker u_lrutlb_checker (.*);

@@ verif/lru_page_replacer_with_fifo_tlb_tb.sv @@
`timescale 1ns / 100ps

module lru_page_replacer_with_fifo_tlb_tb;
    import lrutlb_pkg::*;

    localparam int FRAME_SLOTS   = 8;
    localparam int TLB_SLOTS     = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_REFS    = 225;
    // Result number at which the receiver goes quiet for a long stretch.
    localparam int CHOKE_AT      = 300;
    localparam int CHOKE_CYCLES  = 400;

    localparam longint unsigned ACCESS_SAT = 64'd262143;
    localparam longint unsigned TIME_SAT   = 64'h00FF_FFFF_FFFF;
    localparam longint unsigned COUNT_SAT  = 64'h0000_0000_FFFF_FFFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;  // page_number[15:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // outcome[1:0], evicted_valid[2], evicted_page[18:3], frame_index[21:19],
    // access_time[39:22], fault_total[71:40], time_total[111:72],
    // reference_total[143:112]
    logic [OUT_W-1:0]      m_tdata;

    lru_page_replacer_with_fifo_tlb #(
        .FRAMES      (FRAME_SLOTS),
        .TLB_ENTRIES (TLB_SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: configuration, frame table, TLB and totals
    // ------------------------------------------------------------------
    logic [FCOUNT_W-1:0]   frames_cfg = FRAME_COUNT_RST;
    logic [TCOUNT_W-1:0]   tlb_cfg    = TLB_COUNT_RST;
    logic                  tlb_on_cfg = USE_TLB_RST;
    logic [TIME_CFG_W-1:0] tlb_cost   = TLB_TIME_RST;
    logic [TIME_CFG_W-1:0] mem_cost   = MEM_TIME_RST;
    logic [TIME_CFG_W-1:0] fault_cost = FAULT_TIME_RST;

    bit [PAGE_W-1:0] resident_page [FRAME_SLOTS];
    int              resident_cnt;
    int              recency [FRAME_SLOTS];   // 0 = least recently used
    bit [PAGE_W-1:0] tlb_tag [TLB_SLOTS];
    bit              tlb_live [TLB_SLOTS];
    int              tlb_age [TLB_SLOTS];     // 0 = oldest live entry
    longint unsigned fault_sum, time_sum, ref_sum;

    // Results predicted for accepted references, oldest first.
    result_t         predicted_results [$];
    logic [IN_W-1:0] pending_pages [$];
    int              refs_queued, refs_taken;
    int              fail_count;
    int              settings_count;
    int              outcome_tally [3];
    int              replace_tally;

    function automatic int clamp_count(int v, int top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic int tlb_slot_of(bit [PAGE_W-1:0] page);
        int i;
        for (i = 0; i < TLB_SLOTS; i++)
            if (tlb_live[i] && tlb_tag[i] == page)
                return i;
        return -1;
    endfunction

    // Drop one TLB entry and close the gap it leaves in the FIFO order.
    function automatic void tlb_evict(int slot);
        int i, r;
        r = tlb_age[slot];
        tlb_live[slot] = 1'b0;
        for (i = 0; i < TLB_SLOTS; i++)
            if (tlb_live[i] && tlb_age[i] > r)
                tlb_age[i]--;
    endfunction

    // Enter a page as the newest TLB entry; drop only the oldest one when full,
    // even if the limit was lowered below the live count.
    function automatic void tlb_fill(bit [PAGE_W-1:0] page);
        int i, live, cap;
        live = 0;
        cap = clamp_count(tlb_cfg, TLB_SLOTS);
        for (i = 0; i < TLB_SLOTS; i++)
            if (tlb_live[i])
                live++;
        if (live >= cap)
        begin
            for (i = 0; i < TLB_SLOTS; i++)
                if (tlb_live[i] && tlb_age[i] == 0)
                begin
                    tlb_evict(i);
                    break;
                end
            live--;
        end
        for (i = 0; i < TLB_SLOTS; i++)
            if (!tlb_live[i])
            begin
                tlb_live[i] = 1'b1;
                tlb_tag[i]  = page;
                tlb_age[i]  = live;
                return;
            end
    endfunction

    // Move a frame to the most recently used position.
    function automatic void recency_refresh(int f);
        int i, r;
        r = recency[f];
        for (i = 0; i < resident_cnt; i++)
            if (recency[i] > r)
                recency[i]--;
        recency[f] = resident_cnt - 1;
    endfunction

    // Resolve one page reference against the shadow state and return the result
    // the block must produce for it.
    function automatic result_t resolve_reference(logic [IN_W-1:0] page_in);
        result_t         res;
        bit [PAGE_W-1:0] page;
        int              i, frame, found, cap;
        longint unsigned cost, t, m, f;
        res   = '0;
        page  = page_in;
        t     = tlb_cost;
        m     = mem_cost;
        f     = fault_cost;
        cap   = clamp_count(frames_cfg, FRAME_SLOTS);
        found = -1;
        frame = 0;
        for (i = 0; i < resident_cnt; i++)
            if (resident_page[i] == page)
            begin
                found = i;
                break;
            end
        if (found >= 0)
        begin
            frame = found;
            if (tlb_on_cfg && tlb_slot_of(page) >= 0)
            begin
                res.outcome = OUTCOME_TLB_HIT;
                cost = t + m;
            end
            else if (tlb_on_cfg)
            begin
                tlb_fill(page);
                res.outcome = OUTCOME_TABLE_HIT;
                cost = 2 * t + 2 * m;
            end
            else
            begin
                res.outcome = OUTCOME_TABLE_HIT;
                cost = 2 * m;
            end
            recency_refresh(frame);
        end
        else
        begin
            res.outcome = OUTCOME_FAULT;
            // Replace in place whenever the table is at or above its limit.
            if (resident_cnt >= cap && resident_cnt > 0)
            begin
                for (i = 0; i < resident_cnt; i++)
                    if (recency[i] == 0)
                    begin
                        frame = i;
                        break;
                    end
                res.evicted_valid = 1'b1;
                res.evicted_page  = resident_page[frame];
                // The victim leaves the TLB even while the TLB is bypassed.
                found = tlb_slot_of(resident_page[frame]);
                if (found >= 0)
                    tlb_evict(found);
                resident_page[frame] = page;
                recency_refresh(frame);
                replace_tally++;
            end
            else
            begin
                frame = resident_cnt;
                resident_page[frame] = page;
                recency[frame] = resident_cnt;
                resident_cnt++;
            end
            if (tlb_on_cfg)
                tlb_fill(page);
            cost = f + 2 * m + (tlb_on_cfg ? 2 * t : 64'd0);
            if (fault_sum < COUNT_SAT)
                fault_sum++;
        end
        if (ref_sum < COUNT_SAT)
            ref_sum++;
        // The running time takes the full cost; only the per-reference field clips.
        time_sum = (TIME_SAT - time_sum < cost) ? TIME_SAT : time_sum + cost;
        outcome_tally[res.outcome]++;

        res.frame_index     = FRAME_O_W'(frame);
        res.access_time     = ACCESS_W'((cost > ACCESS_SAT) ? ACCESS_SAT : cost);
        res.fault_total     = CNT_W'(fault_sum);
        res.time_total      = TOTAL_W'(time_sum);
        res.reference_total = CNT_W'(ref_sum);
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // with occasional calm stretches of back-to-back traffic.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued page references, predict each accepted transfer
    // ------------------------------------------------------------------
    int send_gap  = 0;
    int send_calm = 0;

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predicted_results = {predicted_results, resolve_reference(s_tdata)};
            refs_taken++;
        end
        // Hold the current item until it transfers; then idle or advance.
        if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_pages.size() != 0)
            begin
                s_tdata  <= pending_pages[0];
                pending_pages.delete(0);
                s_tvalid <= 1'b1;
                send_gap = idle_len(send_calm);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drive ready, compare each result transfer with the oldest
    // prediction
    // ------------------------------------------------------------------
    int      recv_stall   = 0;
    int      recv_calm    = 0;
    int      choke_left   = 0;
    bit      choke_done   = 1'b0;
    int      results_seen = 0;
    result_t seen_res, want_res;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            seen_res = m_tdata;
            results_seen++;
            if (predicted_results.size() == 0)
            begin
                $error("result transfer with no reference pending");
                fail_count++;
            end
            else
            begin
                want_res = predicted_results[0];
                predicted_results.delete(0);
                check_field("outcome", want_res.outcome, seen_res.outcome);
                check_field("evicted_valid", want_res.evicted_valid, seen_res.evicted_valid);
                check_field("evicted_page", want_res.evicted_page, seen_res.evicted_page);
                check_field("frame_index", want_res.frame_index, seen_res.frame_index);
                check_field("access_time", want_res.access_time, seen_res.access_time);
                check_field("fault_total", want_res.fault_total, seen_res.fault_total);
                check_field("time_total", want_res.time_total, seen_res.time_total);
                check_field("reference_total", want_res.reference_total,
                            seen_res.reference_total);
            end
        end
        // Once, mid-run, hold off long enough for the block to back up and
        // stall its input while the driver keeps offering.
        if (!choke_done && results_seen >= CHOKE_AT)
        begin
            choke_done = 1'b1;
            choke_left = CHOKE_CYCLES;
        end
        if (choke_left > 0)
        begin
            choke_left--;
            m_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            recv_stall = idle_len(recv_calm);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic queue_ref(logic [IN_W-1:0] page);
        pending_pages = {pending_pages, page};
        refs_queued++;
    endtask

    // Wait until every queued reference has transferred and every result has
    // come back, then let the pipeline settle.
    task automatic wait_idle();
        while (refs_taken != refs_queued || predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; leave valid high so back-to-back writes need no
    // second assignment in the same step.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FRAME_COUNT: frames_cfg = value[FCOUNT_W-1:0];
            REG_TLB_COUNT:   tlb_cfg    = value[TCOUNT_W-1:0];
            REG_USE_TLB:     tlb_on_cfg = value[0];
            REG_TLB_TIME:    tlb_cost   = value;
            REG_MEM_TIME:    mem_cost   = value;
            REG_FAULT_TIME:  fault_cost = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] fr, logic [CFG_DATA_W-1:0] tl,
                             logic [CFG_DATA_W-1:0] on, logic [CFG_DATA_W-1:0] tt,
                             logic [CFG_DATA_W-1:0] mt, logic [CFG_DATA_W-1:0] ft);
        write_reg(REG_FRAME_COUNT, fr);
        write_reg(REG_TLB_COUNT, tl);
        write_reg(REG_USE_TLB, on);
        write_reg(REG_TLB_TIME, tt);
        write_reg(REG_MEM_TIME, mt);
        write_reg(REG_FAULT_TIME, ft);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 200));
    endfunction

    // Random setting: mostly in-range limits, sometimes zero or oversized,
    // with junk in the unused upper data bits now and then.
    task automatic configure_random();
        int                    r;
        logic [FCOUNT_W-1:0]   fr;
        logic [TCOUNT_W-1:0]   tl;
        logic [CFG_DATA_W-1:0] junk;
        r = $urandom_range(0, 9);
        fr = (r == 0) ? FCOUNT_W'(0) :
             (r == 1) ? FCOUNT_W'($urandom_range(9, 15)) :
                        FCOUNT_W'($urandom_range(1, FRAME_SLOTS));
        r = $urandom_range(0, 9);
        tl = (r == 0) ? TCOUNT_W'(0) :
             (r == 1) ? TCOUNT_W'($urandom_range(5, 7)) :
                        TCOUNT_W'($urandom_range(1, TLB_SLOTS));
        junk = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
        configure({junk[CFG_DATA_W-1:FCOUNT_W], fr},
                  {junk[CFG_DATA_W-1:TCOUNT_W], tl},
                  {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 3) != 0)},
                  pick_cost(), pick_cost(), pick_cost());
    endtask

    // Mostly a small working set so hits of both kinds occur, with stray
    // pages and immediate repeats mixed in.
    task automatic queue_random_refs(int n);
        logic [PAGE_W-1:0] pool [12];
        logic [PAGE_W-1:0] last_page;
        int                pool_n, r, k;
        pool_n = $urandom_range(2, 12);
        for (k = 0; k < 12; k++)
            pool[k] = PAGE_W'($urandom);
        last_page = pool[0];
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r >= 25)
                last_page = pool[$urandom_range(0, pool_n - 1)];
            else if (r >= 10)
                last_page = PAGE_W'($urandom);
            queue_ref(last_page);
        end
    endtask

    initial
    begin
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fill all three frames, TLB hit, then replace the LRU
        // page and drop it from the TLB.
        queue_ref(16'h0000);
        queue_ref(16'hFFFF);
        queue_ref(16'h0000);
        queue_ref(16'h0001);
        queue_ref(16'h0002);
        queue_ref(16'h0000);
        queue_ref(16'hFFFF);
        wait_idle();

        // Largest table, single-entry TLB for table hits, largest costs so the
        // fault cost clips.
        configure(16'd8, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_ref(16'h0003);
        queue_ref(16'h0004);
        queue_ref(16'h5555);
        queue_ref(16'hAAAA);
        queue_ref(16'h0000);
        queue_ref(16'h0001);
        queue_ref(16'h0003);
        queue_ref(16'h0000);
        wait_idle();

        // Zero limits act as one and shrink below the resident count; TLB
        // bypassed, zero costs.
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_ref(16'hAAAA);
        queue_ref(16'h5555);
        queue_ref(16'h5555);
        queue_ref(16'h0001);
        queue_ref(16'h8000);
        queue_ref(16'h7FFF);
        queue_ref(16'hFFFE);
        wait_idle();

        // Oversized limits clamp to the table sizes; upper data bits ignored.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'd0, 16'hFFFF);
        queue_ref(16'h1234);
        queue_ref(16'hEDCB);
        queue_ref(16'h1234);
        queue_ref(16'h8000);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure_random();
            queue_random_refs(PHASE_REFS);
            wait_idle();
        end
        repeat (8) @(posedge clk);

        $display("Covered %0d references over %0d register settings plus reset defaults:",
                 refs_taken, settings_count);
        $display("  %0d TLB hits, %0d table hits, %0d faults (%0d replacements)",
                 outcome_tally[OUTCOME_TLB_HIT], outcome_tally[OUTCOME_TABLE_HIT],
                 outcome_tally[OUTCOME_FAULT], replace_tally);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lrutlb_pkg.sv
rtl/core/lrutlb_tlb.sv
rtl/core/lru_page_replacer_with_fifo_tlb.sv
rtl/core/lrutlb_checker.sv
verif/lru_page_replacer_with_fifo_tlb_tb.sv
